// ----- hdl/srcc_pkg.sv -----
`timescale 1ns / 1ps

package srcc_pkg;

  // Default frame store depth and kernel limits.
  localparam int MAX_PIXELS_DEF = 65536;
  localparam int MAX_TAPS       = 15;
  localparam int HALF_MAX       = (MAX_TAPS - 1) / 2;

  localparam int PIX_W     = 16;
  localparam int ADDR_W    = 16;
  localparam int DIM_W     = 9;
  localparam int DIM_MAX   = 256;
  localparam int HALF_W    = 3;
  localparam int BANK_W    = 64;
  localparam int NUM_BANKS = 4;
  localparam int FRAC_BITS = 14;

  // Fifteen products of 16 x 16 bits fit in 35 signed bits.
  localparam int ACC_W = 35;

  localparam int CFG_IDX_W = 3;

  // Request function codes.
  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_BANK_0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_BANK_1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_BANK_2   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_BANK_3   = 3'd7;

  typedef logic signed [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic                  func;
    logic [ADDR_W-1:0]     pixel_addr;
    pixel_t                pixel_value;
  } in_item_t;

  typedef struct packed {
    pixel_t                filtered_value;
    logic [ADDR_W-1:0]     result_addr;
  } out_item_t;

endpackage

// ----- hdl/srcc_frame_mem.sv -----
`timescale 1ns / 1ps

module srcc_frame_mem #(
  parameter int DEPTH = srcc_pkg::MAX_PIXELS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  srcc_pkg::pixel_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output srcc_pkg::pixel_t rd_data
);

  import srcc_pkg::*;

  // Single-port-write, single-port-read store with registered read data.
  pixel_t mem [DEPTH];
  pixel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/separable_row_column_convolution.sv -----
`timescale 1ns / 1ps

// Frame store with a one-dimensional filter on top. A write request stores one signed
// 16-bit pixel at a raster address and leaves the block ready for the next request. A
// compute request returns the convolution centred on the pixel at its address, along the
// row or down the column, using 2*half+1 signed Q2.14 taps; neighbors outside the row
// (horizontal) or outside the image (vertical) count as zero, and the sum is truncated
// toward zero and saturated to 16 bits. A compute request occupies the block from
// acceptance to the next acceptance: four steps of a 4-bit-per-cycle remainder unit that
// finds the pixel's column, one tap per cycle through the single frame store read port
// and the shared multiply-accumulate unit, a step that drains the read pipeline and one
// that rounds and loads the result. While that runs in_stall is high. A finished result
// sits in an output register, so a new request is taken while the previous result still
// waits. If that previous result is still held when the next one is ready, the finishing
// step waits until it is taken.
// Configuration writes are always ready and must be issued only while the block is idle.
// The frame store has no reset; reading a pixel that was never written gives garbage.
module separable_row_column_convolution #(
  parameter int MAX_PIXELS = srcc_pkg::MAX_PIXELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,

  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  srcc_pkg::in_item_t                   in_data,

  output logic                                 out_valid,
  input  logic                                 out_stall,
  output srcc_pkg::out_item_t                  out_data,

  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srcc_pkg::BANK_W-1:0]          cfg_wdata
);

  import srcc_pkg::*;

  localparam int AW = $clog2(MAX_PIXELS);

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_TAP    = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [DIM_W-1:0]  image_width_r;
  logic [DIM_W-1:0]  image_height_r;
  logic              vertical_mode_r;
  logic [HALF_W-1:0] kernel_half_width_r;
  logic [BANK_W-1:0] tap_bank_r [NUM_BANKS];

  // Per-request working registers.
  logic [DIM_W-1:0]        w_r;
  logic [16:0]             bounds_r;
  logic [HALF_W-1:0]       half_r;
  logic                    vert_r;
  logic                    in_img_r;
  logic [ADDR_W-1:0]       addr_r;
  logic signed [17:0]      j_r;
  logic [DIM_W-1:0]        stride_r;
  logic signed [9:0]       c_r;
  logic [3:0]              k_r;
  logic [DIM_W-1:0]        rem_r;
  logic [ADDR_W-1:0]       div_sh_r;
  logic [1:0]              div_cnt_r;
  logic                    valid_d_r;
  pixel_t                  tap_d_r;
  logic                    mac_en_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic in_fire;
  logic out_fire;
  logic cfg_fire;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective geometry at request acceptance. Zero dimensions act as one, oversized as 256.
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [HALF_W-1:0] half_eff;
  logic [16:0]       area;
  logic [11:0]       start_off;
  logic signed [17:0] j_start;

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width_r > DIM_W'(DIM_MAX)) begin
      w_eff = DIM_W'(DIM_MAX);
    end else begin
      w_eff = image_width_r;
    end
    if (image_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height_r > DIM_W'(DIM_MAX)) begin
      h_eff = DIM_W'(DIM_MAX);
    end else begin
      h_eff = image_height_r;
    end
    half_eff = (kernel_half_width_r > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX)
                                                          : kernel_half_width_r;
    area = 17'(w_eff * h_eff);
    // The first tap sits half pixels to the left, or half rows above.
    if (vertical_mode_r) begin
      start_off = 12'(half_eff * w_eff);
    end else begin
      start_off = {9'b0, half_eff};
    end
    j_start = $signed({2'b00, in_data.pixel_addr}) - $signed({6'b0, start_off});
  end

  // Remainder unit: four restoring steps per cycle give the column of the center pixel.
  logic [DIM_W:0]   div_work;
  logic [DIM_W-1:0] rem_nxt;

  always_comb begin
    div_work = {1'b0, rem_r};
    for (int b = 0; b < 4; b++) begin
      div_work = {div_work[DIM_W-1:0], div_sh_r[ADDR_W-1-b]};
      if (div_work >= {1'b0, w_r}) begin
        div_work = div_work - {1'b0, w_r};
      end
    end
    rem_nxt = div_work[DIM_W-1:0];
  end

  // Tap qualification: the neighbor must lie in the image, in the store and, when running
  // along a row, in the same row as the center pixel.
  logic             tap_ok;
  logic             col_ok;
  logic [BANK_W-1:0] bank_sel;
  pixel_t           tap_cur;

  always_comb begin
    col_ok = vert_r || (!c_r[9] && (c_r < $signed({1'b0, w_r})));
    tap_ok = in_img_r && !j_r[17] && (j_r < $signed({1'b0, bounds_r}))
             && (32'(j_r) < MAX_PIXELS) && col_ok;
    bank_sel = tap_bank_r[k_r[3:2]];
    tap_cur  = bank_sel[16*k_r[1:0] +: 16];
  end

  // Frame store.
  logic   mem_wr_en;
  logic   mem_rd_en;
  pixel_t mem_rd_data;

  assign mem_wr_en = in_fire && (in_data.func == FUNC_WRITE)
                     && (32'(in_data.pixel_addr) < MAX_PIXELS);
  assign mem_rd_en = (state_r == S_TAP) && tap_ok;

  srcc_frame_mem #(
    .DEPTH (MAX_PIXELS)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (AW'(in_data.pixel_addr)),
    .wr_data (in_data.pixel_value),
    .rd_en   (mem_rd_en),
    .rd_addr (AW'(j_r)),
    .rd_data (mem_rd_data)
  );

  // Shared multiply-accumulate unit, one product per cycle. A newly accepted request
  // starts from an empty accumulator.
  logic signed [31:0]      product;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    product = mem_rd_data * tap_d_r;
    acc_nxt = acc_r;
    if (in_fire) begin
      acc_nxt = '0;
    end else if (mac_en_r && valid_d_r) begin
      acc_nxt = acc_r + ACC_W'(product);
    end
  end

  // Round toward zero, then saturate to the pixel range.
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] quot;
  pixel_t                  sat_value;

  always_comb begin
    acc_adj = acc_r + (acc_r[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : '0);
    quot    = acc_adj >>> FRAC_BITS;
    if (quot > ACC_W'(32767)) begin
      sat_value = 16'sh7FFF;
    end else if (quot < -ACC_W'(32768)) begin
      sat_value = 16'sh8000;
    end else begin
      sat_value = quot[15:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_data.func == FUNC_COMPUTE)) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_r == 2'd3) begin
          state_nxt = S_TAP;
        end
      end
      S_TAP: begin
        if (k_r == {half_r, 1'b0}) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mac_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mac_en_r <= (state_r == S_TAP);
      if (state_r == S_FINISH && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r       <= DIM_W'(DIM_MAX);
      image_height_r      <= DIM_W'(DIM_MAX);
      vertical_mode_r     <= 1'b0;
      kernel_half_width_r <= '0;
      for (int b = 0; b < NUM_BANKS; b++) begin
        tap_bank_r[b] <= '0;
      end
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r       <= cfg_wdata[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r      <= cfg_wdata[DIM_W-1:0];
        CFG_VERTICAL:     vertical_mode_r     <= cfg_wdata[0];
        CFG_HALF_WIDTH:   kernel_half_width_r <= cfg_wdata[HALF_W-1:0];
        CFG_TAP_BANK_0:   tap_bank_r[0]       <= cfg_wdata;
        CFG_TAP_BANK_1:   tap_bank_r[1]       <= cfg_wdata;
        CFG_TAP_BANK_2:   tap_bank_r[2]       <= cfg_wdata;
        CFG_TAP_BANK_3:   tap_bank_r[3]       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Datapath registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          w_r       <= w_eff;
          bounds_r  <= area;
          half_r    <= half_eff;
          vert_r    <= vertical_mode_r;
          in_img_r  <= ({1'b0, in_data.pixel_addr} < area);
          addr_r    <= in_data.pixel_addr;
          j_r       <= j_start;
          stride_r  <= vertical_mode_r ? w_eff : DIM_W'(1);
          rem_r     <= '0;
          div_sh_r  <= in_data.pixel_addr;
          div_cnt_r <= '0;
          k_r       <= '0;
        end
      end
      S_DIV: begin
        rem_r     <= rem_nxt;
        div_sh_r  <= {div_sh_r[ADDR_W-5:0], 4'b0};
        div_cnt_r <= div_cnt_r + 2'd1;
        c_r       <= $signed({1'b0, rem_nxt}) - $signed({7'b0, half_r});
      end
      S_TAP: begin
        valid_d_r <= tap_ok;
        tap_d_r   <= tap_cur;
        k_r       <= k_r + 4'd1;
        j_r       <= j_r + $signed({9'b0, stride_r});
        c_r       <= c_r + 10'sd1;
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_data_r.filtered_value <= sat_value;
          out_data_r.result_addr    <= addr_r;
        end
      end
      default: begin
      end
    endcase
  end

  // A new result only ever comes from the finishing step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result loaded outside the finishing step");

  // The tap counter never runs past the last tap of the kernel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAP) |-> (k_r <= {half_r, 1'b0}))
    else $error("tap counter beyond kernel");

  // The partial remainder stays below the row width.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < w_r))
    else $error("column remainder out of range");

  // The drain cycle is always followed by rounding, so the last product is counted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_FINISH) && !mac_en_r)
    else $error("accumulator pipeline not drained before rounding");

endmodule

// ----- bench/tb_separable_row_column_convolution.sv -----
`timescale 1ns / 1ps

module tb_separable_row_column_convolution;
  import srcc_pkg::*;

  localparam int STORE_DEPTH = MAX_PIXELS_DEF;

  // Waiting a little longer than a compute request under the widest kernel holds the
  // block lets any request still in flight finish before the configuration changes.
  localparam int SETTLE_CYCLES = 2 * HALF_MAX + 10;

  // The longest legal stretch without any handshake is the longest sender gap, a
  // full-width compute and a result held by a run of receiver stalls. The watchdog
  // limit is many times that.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_PRINTED    = 100;

  // All sixteen tap slots of the four banks, bank 0 in the low word.
  typedef logic [NUM_BANKS-1:0][BANK_W-1:0] bank_set_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BANK_W-1:0]    cfg_wdata = '0;

  separable_row_column_convolution dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The testbench keeps its own copy of the frame store and of the registers. The copy
  // is updated at the clock edge where a request or a register write is accepted, so
  // it always matches what the block holds at that point.
  pixel_t            frame_copy    [STORE_DEPTH];
  bit                pixel_written [STORE_DEPTH];
  logic [DIM_W-1:0]  width_reg     = DIM_W'(DIM_MAX);
  logic [DIM_W-1:0]  height_reg    = DIM_W'(DIM_MAX);
  logic              vertical_reg  = 1'b0;
  logic [HALF_W-1:0] half_reg      = '0;
  bank_set_t         tap_banks     = '0;

  // Filtered pixels that compute requests have asked for, oldest first.
  out_item_t pending_filtered [$];

  int error_count    = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // A width or height of zero acts as one, anything above the maximum as the maximum.
  function automatic int clamp_dim(logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM_MAX) return DIM_MAX;
    return int'(raw);
  endfunction

  function automatic int image_bounds();
    return clamp_dim(width_reg) * clamp_dim(height_reg);
  endfunction

  function automatic longint tap_weight(int k);
    pixel_t t;
    t = tap_banks[2'(k / 4)][(k % 4) * PIX_W +: PIX_W];
    return longint'(t);
  endfunction

  // The filtered value at one raster address. Neighbors that fall off the image, or
  // off the row in horizontal mode, contribute nothing. The Q2.14 sum is truncated
  // toward zero, which is what integer division does, and then saturated.
  function automatic out_item_t filter_at(logic [ADDR_W-1:0] addr);
    out_item_t res;
    longint    w, bounds, centre, half, j, acc, q;
    w      = clamp_dim(width_reg);
    bounds = w * clamp_dim(height_reg);
    half   = half_reg;
    centre = addr;
    acc    = 0;
    if (centre < bounds) begin
      for (int k = 0; k <= 2 * half; k++) begin
        if (vertical_reg) j = centre + (k - half) * w;
        else j = centre + (k - half);
        if (j < 0 || j >= bounds) continue;
        if (!vertical_reg && j / w != centre / w) continue;
        acc += longint'(frame_copy[ADDR_W'(j)]) * tap_weight(k);
      end
    end
    q = acc / (longint'(1) << FRAC_BITS);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res.filtered_value = pixel_t'(q);
    res.result_addr    = addr;
    return res;
  endfunction

  function automatic void note_request(in_item_t req);
    if (req.func == FUNC_WRITE) begin
      frame_copy[req.pixel_addr]    = req.pixel_value;
      pixel_written[req.pixel_addr] = 1'b1;
    end else begin
      pending_filtered.push_back(filter_at(req.pixel_addr));
    end
  endfunction

  // Register writes keep only the bits the register has.
  function automatic void note_register(logic [CFG_IDX_W-1:0] idx, logic [BANK_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg    = data[DIM_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg   = data[DIM_W-1:0];
      CFG_VERTICAL:     vertical_reg = data[0];
      CFG_HALF_WIDTH:   half_reg     = data[HALF_W-1:0];
      CFG_TAP_BANK_0, CFG_TAP_BANK_1, CFG_TAP_BANK_2, CFG_TAP_BANK_3: begin
        tap_banks[2'(idx - CFG_TAP_BANK_0)] = data;
      end
      default: ;
    endcase
  endfunction

  // Pixels lean toward the extremes so that sums saturate often, and toward small
  // values so that truncation of small fractions shows up.
  function automatic pixel_t rand_pixel();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return pixel_t'($urandom_range(16)) - 16'sd8;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_tap();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh4000;
      3:       return 16'shC000;
      4:       return pixel_t'($urandom_range(64)) - 16'sd32;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // The top slot of the last bank is unused, so it gets random bits as well.
  function automatic bank_set_t random_banks();
    bank_set_t banks;
    for (int t = 0; t < 4 * NUM_BANKS; t++) begin
      banks[2'(t / 4)][(t % 4) * PIX_W +: PIX_W] = rand_tap();
    end
    return banks;
  endfunction

  // A raster address inside the image, often on its first or last row or column.
  function automatic logic [ADDR_W-1:0] inside_addr();
    int w, h, row, col;
    w   = clamp_dim(width_reg);
    h   = clamp_dim(height_reg);
    row = $urandom_range(h - 1);
    col = $urandom_range(w - 1);
    case ($urandom_range(5))
      0:       col = 0;
      1:       col = w - 1;
      2:       row = 0;
      3:       row = h - 1;
      default: ;
    endcase
    return ADDR_W'(row * w + col);
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < MAX_PRINTED) $display("MISMATCH: %s", what);
    error_count++;
  endtask

  // Offers one request, after a random gap when the sender is set to idle, and returns
  // at the edge where the block takes it. Valid stays high afterwards so that the next
  // request can follow without a bubble.
  task automatic send_request(in_item_t req);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    note_request(req);
  endtask

  task automatic send_write(int addr, pixel_t value);
    in_item_t req;
    req.func        = FUNC_WRITE;
    req.pixel_addr  = ADDR_W'(addr);
    req.pixel_value = value;
    send_request(req);
  endtask

  // The pixel field means nothing to a compute request; it carries random bits anyway.
  task automatic send_compute(int addr);
    in_item_t req;
    req.func        = FUNC_COMPUTE;
    req.pixel_addr  = ADDR_W'(addr);
    req.pixel_value = rand_pixel();
    send_request(req);
  endtask

  // The sender stops until every filtered pixel asked for has come back, then lets the
  // block settle. A write request leaves nothing to wait for, hence the extra cycles.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid is left high; the caller lowers it after its last write.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [BANK_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    note_register(idx, data);
  endtask

  // Every register is rewritten each time, and only once the block has gone idle.
  task automatic configure(input logic [BANK_W-1:0] width_raw, height_raw, vertical_raw,
                           half_raw, input bank_set_t banks);
    wait_for_quiet();
    write_register(CFG_IMAGE_WIDTH, width_raw);
    write_register(CFG_IMAGE_HEIGHT, height_raw);
    write_register(CFG_VERTICAL, vertical_raw);
    write_register(CFG_HALF_WIDTH, half_raw);
    write_register(CFG_TAP_BANK_0, banks[0]);
    write_register(CFG_TAP_BANK_1, banks[1]);
    write_register(CFG_TAP_BANK_2, banks[2]);
    write_register(CFG_TAP_BANK_3, banks[3]);
    cfg_valid <= 1'b0;
  endtask

  // Every pixel a compute request may touch must hold a written value, so any gap in
  // the image is filled before computing starts.
  task automatic fill_image();
    for (int a = 0; a < image_bounds(); a++) begin
      if (!pixel_written[ADDR_W'(a)]) send_write(a, rand_pixel());
    end
  endtask

  // Straight after reset the image is 256 by 256 with a single zero tap, so both ends
  // of the store filter to zero.
  task automatic test_reset_state();
    send_write(0, 16'sh7FFF);
    send_write(STORE_DEPTH - 1, 16'sh8000);
    send_compute(0);
    send_compute(STORE_DEPTH - 1);
  endtask

  // A 3 by 2 image under the widest kernel, so the taps reach past both ends of each
  // row. Garbage above the register widths must be dropped. With every tap at -2.0 the
  // first row saturates low and the second row saturates high. Addresses past the
  // image filter to zero.
  task automatic test_row_edges_and_saturation();
    configure(64'hFFFF_FFFF_FFFF_FE03, 64'd2, 64'd0, 64'hF7, {16{16'h8000}});
    send_write(0, 16'sh7FFF);
    send_write(1, 16'sh8000);
    send_write(2, 16'sh7FFF);
    send_write(3, 16'sh8000);
    send_write(4, 16'sd1);
    send_write(5, -16'sd1);
    send_compute(0);
    send_compute(2);
    send_compute(4);
    send_compute(6);
    send_compute(STORE_DEPTH - 1);
  endtask

  // The same image down its columns with three taps. Taps just off one half and minus
  // one half leave fractions of both signs, which must be cut toward zero.
  task automatic test_column_mode_and_truncation();
    configure(64'h203, 64'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, {16{16'h2001}});
    send_compute(1);
    send_compute(4);
    send_compute(5);
    configure(64'h203, 64'd2, 64'd1, 64'd1, {16{16'hE001}});
    send_compute(0);
    send_compute(4);
  endtask

  // One phase: new geometry and taps, a fill of the image, then a random mix of
  // requests. Halfway through, the sender waits for every result to come back.
  task automatic run_phase(int p, int width_sel, int height_sel, int count);
    logic [BANK_W-1:0] width_raw, height_raw, vertical_raw, half_raw;
    case (p % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 58;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 58;
      end
      default: begin
        send_idle_pct  = 16;
        recv_stall_pct = 16;
      end
    endcase
    width_raw                 = {$urandom, $urandom};
    width_raw[DIM_W-1:0]      = DIM_W'(width_sel);
    height_raw                = {$urandom, $urandom};
    height_raw[DIM_W-1:0]     = DIM_W'(height_sel);
    vertical_raw              = {$urandom, $urandom};
    half_raw                  = {$urandom, $urandom};
    half_raw[HALF_W-1:0]      = HALF_W'((p * 3) % 8);
    configure(width_raw, height_raw, vertical_raw, half_raw, random_banks());
    fill_image();
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_quiet();
      case ($urandom_range(19))
        0, 1, 2, 3, 4: send_write(inside_addr(), rand_pixel());
        5:             send_write($urandom_range(STORE_DEPTH - 1), rand_pixel());
        6, 7:          send_compute($urandom_range(STORE_DEPTH - 1, image_bounds()));
        default:       send_compute(inside_addr());
      endcase
    end
  endtask

  // Dimensions cover single pixels, full-length rows and columns, zero and oversize
  // register values, and a few ordinary shapes. Images stay at 256 pixels or fewer so
  // that filling them is cheap.
  task automatic test_random_phases();
    run_phase(0, 1, 1, 125);
    run_phase(1, 256, 1, 125);
    run_phase(2, 1, 256, 125);
    run_phase(3, 0, 511, 125);
    run_phase(4, 511, 0, 125);
    run_phase(5, 16, 16, 125);
    run_phase(6, 7, 9, 125);
    run_phase(7, 13, 5, 125);
    run_phase(8, 2, 100, 125);
    run_phase(9, 100, 2, 125);
    run_phase(10, 20, 12, 125);
  endtask

  // The receiver decides each cycle whether to stall, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Each result taken from the block is checked against the oldest filtered pixel that
  // was asked for.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_filtered.size() == 0) begin
        report_mismatch($sformatf("result for address %0d with no request waiting",
                                  out_data.result_addr));
      end else begin
        want = pending_filtered.pop_front();
        if (out_data.filtered_value !== want.filtered_value) begin
          report_mismatch($sformatf("address %0d: filtered_value %0d, want %0d",
                                    want.result_addr, out_data.filtered_value,
                                    want.filtered_value));
        end
        if (out_data.result_addr !== want.result_addr) begin
          report_mismatch($sformatf("result_addr %0d, want %0d",
                                    out_data.result_addr, want.result_addr));
        end
      end
    end
  end

  // Ends the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_separable_row_column_convolution failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_row_edges_and_saturation();
    test_column_mode_and_truncation();
    test_random_phases();
    wait_for_quiet();
    if (error_count == 0) begin
      $display("tb_separable_row_column_convolution passed");
    end else begin
      $display("tb_separable_row_column_convolution failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/srcc_pkg.sv
hdl/srcc_frame_mem.sv
hdl/separable_row_column_convolution.sv
bench/tb_separable_row_column_convolution.sv
